### hdl/circle_octant_rasterizer_macros.svh
// Assertion helpers shared by the checker. All sample on the rising edge of clock.
`ifndef CIRCLE_OCTANT_RASTERIZER_MACROS_SVH
`define CIRCLE_OCTANT_RASTERIZER_MACROS_SVH

// Same-cycle implication, ignored while reset is high
`define COR_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, ignored while reset is high
`define COR_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// Next-cycle implication that also holds across reset
`define COR_ASSERT_NXT_ALL(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hdl/cor_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package cor_pkg;

   // Field widths
   localparam int COORD_BITS  = 16;
   localparam int RADIUS_BITS = 12;
   localparam int OUT_BITS    = (COORD_BITS > RADIUS_BITS) ? COORD_BITS + 1 : RADIUS_BITS + 2;

   // Root unit works on r*r - y*y
   localparam int SQ_BITS = 2 * RADIUS_BITS;

   // Results per step: eight outline points or four fill spans
   localparam int MAX_RESULTS = 8;
   localparam int IDX_BITS    = $clog2(MAX_RESULTS);
   localparam logic [IDX_BITS-1:0] LAST_OUTLINE = IDX_BITS'(MAX_RESULTS - 1);
   localparam logic [IDX_BITS-1:0] LAST_FILL    = IDX_BITS'(MAX_RESULTS / 2 - 1);

   typedef enum logic [0:0] {
      OP_START   = 1'b0,
      OP_ADVANCE = 1'b1
   } opcode_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ROOT,
      ST_EMIT
   } state_type;

   // Controller to datapath
   typedef struct packed {
      logic                load_start;
      logic                kill;
      logic                root_start;
      logic                emit_load;
      logic [IDX_BITS-1:0] emit_index;
      logic                emit_last;
      logic                commit;
   } ctrl_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic active;
      logic x_below_y;
      logic fill_mode;
      logic root_done;
   } dp_status_type;

endpackage

`default_nettype wire

### hdl/circle_octant_rasterizer.sv
`timescale 1ns / 1ps
`default_nettype none

// Circle rasterizer, one octant step per advance request. A start request (opcode 0)
// latches center and radius and returns nothing. An advance request (opcode 1)
// on an active circle returns eight outline points, or four horizontal spans when
// fill_mode is set, for the current (x, y); the last result of a step carries
// last_in_step and every result of the circle's final step carries circle_done.
// Before the results come out the next x is found by a shift-subtract square root
// that resolves one bit per cycle. req_ready is high whenever no step is in
// progress, even while the last result still waits in the output register.
// fill_mode is written through the csr channel, which is always ready, and should
// only change between steps.
module circle_octant_rasterizer
   import cor_pkg::*;
(
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic                          req_opcode,
   input  wire logic signed [COORD_BITS-1:0]  req_center_x,
   input  wire logic signed [COORD_BITS-1:0]  req_center_y,
   input  wire logic [RADIUS_BITS-1:0]        req_radius,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic signed [OUT_BITS-1:0]         rsp_span_x_start,
   output logic signed [OUT_BITS-1:0]         rsp_span_x_end,
   output logic signed [OUT_BITS-1:0]         rsp_span_row,
   output logic                               rsp_last_in_step,
   output logic                               rsp_circle_done,
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic                          csr_fill_mode
);

   ctrl_cmd_type  cmd;
   dp_status_type status;

   assign csr_ready = 1'b1;

   cor_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_opcode (req_opcode),
      .req_ready  (req_ready),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .status     (status),
      .cmd        (cmd)
   );

   cor_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .csr_we           (csr_valid && csr_ready),
      .csr_fill_mode    (csr_fill_mode),
      .req_center_x     (req_center_x),
      .req_center_y     (req_center_y),
      .req_radius       (req_radius),
      .rsp_span_x_start (rsp_span_x_start),
      .rsp_span_x_end   (rsp_span_x_end),
      .rsp_span_row     (rsp_span_row),
      .rsp_last_in_step (rsp_last_in_step),
      .rsp_circle_done  (rsp_circle_done)
   );

endmodule

`default_nettype wire

### hdl/cor_sqrt.sv
`timescale 1ns / 1ps
`default_nettype none

// Bit-pair integer square root, one result bit per cycle, rounded to nearest
module cor_sqrt
   import cor_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   input  wire logic [SQ_BITS-1:0]     operand,
   output logic                        done,
   output logic [RADIUS_BITS-1:0]      root
);

   logic                   run_ff;
   logic                   done_ff;
   logic [SQ_BITS-1:0]     rem_ff;
   logic [SQ_BITS-1:0]     res_ff;
   logic [SQ_BITS-1:0]     bit_ff;
   logic [SQ_BITS-1:0]     trial_w;
   logic                   fits_w;
   logic                   round_up_w;

   assign trial_w = res_ff + bit_ff;
   assign fits_w  = (rem_ff >= trial_w);

   // Leftover n - s*s above s means the true root is at least s + 0.5
   assign round_up_w = (rem_ff > res_ff);
   assign root       = res_ff[RADIUS_BITS-1:0] + RADIUS_BITS'(round_up_w);
   assign done       = done_ff;

   // Control
   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= run_ff && bit_ff[0];
         if (start) begin
            run_ff <= 1'b1;
         end else if (run_ff && bit_ff[0]) begin
            run_ff <= 1'b0;
         end
      end
   end

   // Iteration
   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= operand;
         res_ff <= '0;
         bit_ff <= SQ_BITS'(1) << (SQ_BITS - 2);
      end else if (run_ff) begin
         if (fits_w) begin
            rem_ff <= rem_ff - trial_w;
            res_ff <= (res_ff >> 1) + bit_ff;
         end else begin
            res_ff <= res_ff >> 1;
         end
         bit_ff <= bit_ff >> 2;
      end
   end

endmodule

`default_nettype wire

### hdl/cor_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

// Sequencer: accept, run the root, then hand out one result per cycle while the output is not stalled
module cor_ctrl
   import cor_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   input  wire logic          req_opcode,
   output logic               req_ready,
   output logic               rsp_valid,
   input  wire logic          rsp_ready,
   input  wire dp_status_type status,
   output ctrl_cmd_type       cmd
);

   state_type           state_ff, state_in;
   logic [IDX_BITS-1:0] idx_ff, idx_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [IDX_BITS-1:0] last_idx_w;
   logic                accept_w;

   assign req_ready  = (state_ff == ST_IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign accept_w   = req_valid && req_ready;
   assign last_idx_w = status.fill_mode ? LAST_FILL : LAST_OUTLINE;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept_w) begin
               if (req_opcode == OP_START) begin
                  cmd.load_start = 1'b1;
               end else if (status.active) begin
                  if (status.x_below_y) begin
                     cmd.kill = 1'b1;
                  end else begin
                     cmd.root_start = 1'b1;
                     state_in       = ST_ROOT;
                  end
               end
            end
         end
         ST_ROOT: begin
            if (status.root_done) begin
               state_in = ST_EMIT;
               idx_in   = '0;
            end
         end
         ST_EMIT: begin
            // Output register free or draining this cycle
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.emit_load  = 1'b1;
               cmd.emit_index = idx_ff;
               cmd.emit_last  = (idx_ff == last_idx_w);
               if (idx_ff == last_idx_w) begin
                  cmd.commit = 1'b1;
                  state_in   = ST_IDLE;
               end else begin
                  idx_in = idx_ff + IDX_BITS'(1);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Result valid flag
   always_comb begin
      if (cmd.emit_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

endmodule

`default_nettype wire

### hdl/cor_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

// Circle state, next-x root, span arithmetic and the result register
module cor_datapath
   import cor_pkg::*;
(
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire ctrl_cmd_type                  cmd,
   output dp_status_type                      status,
   input  wire logic                          csr_we,
   input  wire logic                          csr_fill_mode,
   input  wire logic signed [COORD_BITS-1:0]  req_center_x,
   input  wire logic signed [COORD_BITS-1:0]  req_center_y,
   input  wire logic [RADIUS_BITS-1:0]        req_radius,
   output logic signed [OUT_BITS-1:0]         rsp_span_x_start,
   output logic signed [OUT_BITS-1:0]         rsp_span_x_end,
   output logic signed [OUT_BITS-1:0]         rsp_span_row,
   output logic                               rsp_last_in_step,
   output logic                               rsp_circle_done
);

   logic                          fill_mode_ff;
   logic signed [COORD_BITS-1:0]  center_col_ff;
   logic signed [COORD_BITS-1:0]  center_row_ff;
   logic [RADIUS_BITS-1:0]        radius_ff;
   logic [RADIUS_BITS-1:0]        x_ff;
   logic [RADIUS_BITS-1:0]        y_ff;
   logic                          active_ff;

   logic signed [OUT_BITS-1:0]    xs_ff, xe_ff, row_ff;
   logic                          last_ff, done_ff;

   logic [RADIUS_BITS-1:0]        ny_w;
   logic [RADIUS_BITS-1:0]        nx_w;
   logic [SQ_BITS-1:0]            rr_w, yy_w, diff_w;
   logic                          root_done_w;
   logic                          step_done_w;

   logic signed [OUT_BITS-1:0]    cx_w, cy_w, xw_w, yw_w;
   logic signed [OUT_BITS-1:0]    cpx_w, cmx_w, cpy_w, cmy_w;
   logic signed [OUT_BITS-1:0]    rpx_w, rmx_w, rpy_w, rmy_w;
   logic signed [OUT_BITS-1:0]    xs_w, xe_w, row_w;

   // Next position: y + 1, x = round(sqrt(r*r - (y+1)*(y+1))) with the difference saturated at zero
   assign ny_w   = y_ff + RADIUS_BITS'(1);
   assign rr_w   = SQ_BITS'(radius_ff) * SQ_BITS'(radius_ff);
   assign yy_w   = SQ_BITS'(ny_w) * SQ_BITS'(ny_w);
   assign diff_w = (rr_w > yy_w) ? rr_w - yy_w : '0;

   cor_sqrt u_sqrt (
      .clock   (clock),
      .reset   (reset),
      .start   (cmd.root_start),
      .operand (diff_w),
      .done    (root_done_w),
      .root    (nx_w)
   );

   // Circle ends once the next x falls below the next y
   assign step_done_w = (nx_w < ny_w);

   assign status.active    = active_ff;
   assign status.x_below_y = (x_ff < y_ff);
   assign status.fill_mode = fill_mode_ff;
   assign status.root_done = root_done_w;

   // Circle state
   always_ff @(posedge clock) begin
      if (reset) begin
         fill_mode_ff  <= 1'b0;
         center_col_ff <= '0;
         center_row_ff <= '0;
         radius_ff     <= '0;
         x_ff          <= '0;
         y_ff          <= '0;
         active_ff     <= 1'b0;
      end else begin
         if (csr_we) begin
            fill_mode_ff <= csr_fill_mode;
         end
         if (cmd.load_start) begin
            center_col_ff <= req_center_x;
            center_row_ff <= req_center_y;
            radius_ff     <= req_radius;
            x_ff          <= req_radius;
            y_ff          <= '0;
            active_ff     <= 1'b1;
         end else if (cmd.kill) begin
            active_ff <= 1'b0;
         end else if (cmd.commit) begin
            x_ff      <= nx_w;
            y_ff      <= ny_w;
            active_ff <= !step_done_w;
         end
      end
   end

   // Symmetric coordinates
   assign cx_w  = OUT_BITS'(center_col_ff);
   assign cy_w  = OUT_BITS'(center_row_ff);
   assign xw_w  = $signed(OUT_BITS'(x_ff));
   assign yw_w  = $signed(OUT_BITS'(y_ff));
   assign cpx_w = cx_w + xw_w;
   assign cmx_w = cx_w - xw_w;
   assign cpy_w = cx_w + yw_w;
   assign cmy_w = cx_w - yw_w;
   assign rpx_w = cy_w + xw_w;
   assign rmx_w = cy_w - xw_w;
   assign rpy_w = cy_w + yw_w;
   assign rmy_w = cy_w - yw_w;

   // Pick the span for this result slot
   always_comb begin
      xs_w  = cpy_w;
      xe_w  = cpy_w;
      row_w = rmx_w;
      if (fill_mode_ff) begin
         unique case (cmd.emit_index)
            IDX_BITS'(0): begin xs_w = cpy_w; xe_w = cmy_w; row_w = rmx_w; end
            IDX_BITS'(1): begin xs_w = cpx_w; xe_w = cmx_w; row_w = rmy_w; end
            IDX_BITS'(2): begin xs_w = cpx_w; xe_w = cmx_w; row_w = rpy_w; end
            default:      begin xs_w = cpy_w; xe_w = cmy_w; row_w = rpx_w; end
         endcase
      end else begin
         unique case (cmd.emit_index)
            IDX_BITS'(0): begin xs_w = cpy_w; row_w = rmx_w; end
            IDX_BITS'(1): begin xs_w = cpx_w; row_w = rmy_w; end
            IDX_BITS'(2): begin xs_w = cpx_w; row_w = rpy_w; end
            IDX_BITS'(3): begin xs_w = cpy_w; row_w = rpx_w; end
            IDX_BITS'(4): begin xs_w = cmy_w; row_w = rpx_w; end
            IDX_BITS'(5): begin xs_w = cmx_w; row_w = rpy_w; end
            IDX_BITS'(6): begin xs_w = cmx_w; row_w = rmy_w; end
            default:      begin xs_w = cmy_w; row_w = rmx_w; end
         endcase
         xe_w = xs_w;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (cmd.emit_load) begin
         xs_ff   <= xs_w;
         xe_ff   <= xe_w;
         row_ff  <= row_w;
         last_ff <= cmd.emit_last;
         done_ff <= step_done_w;
      end
   end

   assign rsp_span_x_start = xs_ff;
   assign rsp_span_x_end   = xe_ff;
   assign rsp_span_row     = row_ff;
   assign rsp_last_in_step = last_ff;
   assign rsp_circle_done  = done_ff;

endmodule

`default_nettype wire

### hdl/cor_checker.sv
`timescale 1ns / 1ps
`default_nettype none

`include "circle_octant_rasterizer_macros.svh"

// Port-level checks for the rasterizer
module cor_checker
   import cor_pkg::*;
(
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_ready,
   input  wire logic                          rsp_valid,
   input  wire logic                          rsp_ready,
   input  wire logic signed [OUT_BITS-1:0]    rsp_span_x_start,
   input  wire logic signed [OUT_BITS-1:0]    rsp_span_x_end,
   input  wire logic signed [OUT_BITS-1:0]    rsp_span_row,
   input  wire logic                          rsp_last_in_step,
   input  wire logic                          rsp_circle_done,
   input  wire logic                          csr_valid,
   input  wire logic                          csr_ready,
   input  wire logic                          csr_fill_mode
);

   logic                      fill_mode_ff;
   logic [3*OUT_BITS+1:0]     rsp_payload_w;

   // Whole result payload, for the hold check
   assign rsp_payload_w = {rsp_span_x_start, rsp_span_x_end, rsp_span_row,
                           rsp_last_in_step, rsp_circle_done};

   // Shadow of the mode register
   always_ff @(posedge clock) begin
      if (reset) begin
         fill_mode_ff <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         fill_mode_ff <= csr_fill_mode;
      end
   end

   `COR_ASSERT_NXT_ALL(a_reset_clears_rsp, reset, !rsp_valid, "result valid after reset")
   `COR_ASSERT_NXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_payload_w), "stalled result changed")
   `COR_ASSERT_IMP(a_outline_point, rsp_valid && !fill_mode_ff, rsp_span_x_start == rsp_span_x_end, "outline result is not a single pixel")
   `COR_ASSERT_IMP(a_no_req_mid_step, rsp_valid && !rsp_last_in_step, !req_ready, "request taken mid step")

endmodule

bind circle_octant_rasterizer cor_checker u_cor_checker (.*);

`default_nettype wire
